[hdl/cset_pkg.sv]
// Shared types and constants for the clock sync event tracker.
`default_nettype none
package cset_pkg;
	localparam int unsigned DefTimebases = 16;

	// Request kinds.
	localparam logic [2:0] KIND_PTP_UPD = 3'd0;
	localparam logic [2:0] KIND_SYS_UPD = 3'd1;
	localparam logic [2:0] KIND_PTP_SUB = 3'd2;
	localparam logic [2:0] KIND_SYS_SUB = 3'd3;
	localparam logic [2:0] KIND_READ    = 3'd4;

	// Flag bit positions.
	localparam int unsigned F_PRANGE  = 0;
	localparam int unsigned F_SYNCED  = 1;
	localparam int unsigned F_GMCHG   = 2;
	localparam int unsigned F_CAPABLE = 3;
	localparam int unsigned F_COMP    = 4;
	localparam int unsigned F_CHANGED = 5;
	localparam int unsigned F_PAVAIL  = 6;
	localparam int unsigned F_SRANGE  = 7;
	localparam int unsigned F_SAVAIL  = 8;
	localparam int unsigned F_PRESENT = 9;

	// One time-base entry as held in the entry memory.
	typedef struct packed {
		logic [63:0] ptp_off;
		logic [63:0] gm_id;
		logic [31:0] ivl;
		logic [63:0] ptp_time;
		logic [63:0] sys_off;
		logic [9:0]  flags;
		logic [31:0] c_prange;
		logic [31:0] c_synced;
		logic [31:0] c_gmchg;
		logic [31:0] c_cap;
		logic [31:0] c_comp;
		logic [31:0] c_srange;
		logic [3:0]  ptp_mask;
		logic [3:0]  comp_mask;
		logic [30:0] ptp_thr;
		logic [3:0]  sys_mask;
		logic [30:0] sys_thr;
	} entry_t;

	// True when a signed offset lies within plus or minus the threshold.
	function automatic logic in_range(input logic signed [63:0] off, input logic [30:0] thr);
		logic signed [63:0] t;
		begin
			t = signed'({33'd0, thr});
			in_range = (off >= -t) && (off <= t);
		end
	endfunction
endpackage
`default_nettype wire

[hdl/clock_sync_event_tracker.sv]
// Top level of the clock sync event tracker: entry memory and its update logic.
//
// Usage: one input channel (in_valid/in_ready) carries requests of five kinds:
// ptp update, sys update, ptp subscribe, sys subscribe, and read-and-clear.
// Only a read produces a result, on the output channel (out_valid/out_ready).
// Each request is handled by a read of the entry memory when it is taken and
// a write-back of the modified entry in the next cycle, during which no new
// request is accepted. A read result is loaded into an output register in
// that write-back cycle and is valid from there; the next request is
// accepted while that result waits, and only a further read stalls until
// the output register is free.
// Reset: after arst_n is released the block sweeps the memory, one entry a
// cycle for TIMEBASES cycles, clearing every entry; no request is accepted
// during the sweep. A stalled receiver holds the result unchanged.
`default_nettype none
module clock_sync_event_tracker #(
	parameter int unsigned TIMEBASES = cset_pkg::DefTimebases
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [3:0]  timebase,
	input  wire logic signed [63:0] clock_offset,
	input  wire logic [63:0] gm_identity,
	input  wire logic signed [31:0] sync_interval,
	input  wire logic        synced_with_gm,
	input  wire logic        as_capable,
	input  wire logic [63:0] timestamp_ns,
	input  wire logic [3:0]  event_mask,
	input  wire logic [3:0]  composite_mask,
	input  wire logic [30:0] offset_threshold,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       status_flags,
	output logic [31:0]      ptp_range_count,
	output logic [31:0]      synced_count,
	output logic [31:0]      gm_change_count,
	output logic [31:0]      capable_count,
	output logic [31:0]      composite_count,
	output logic [31:0]      sys_range_count,
	output logic signed [63:0] ptp_offset,
	output logic [63:0]      ptp_gm_identity,
	output logic signed [31:0] ptp_interval,
	output logic signed [63:0] sys_offset,
	output logic [63:0]      ptp_time
);
	import cset_pkg::*;

	localparam int unsigned AW = (TIMEBASES > 1) ? $clog2(TIMEBASES) : 1;

	// Phase codes.
	localparam logic [1:0] PH_CLEAR = 2'd0;
	localparam logic [1:0] PH_IDLE  = 2'd1;
	localparam logic [1:0] PH_MOD   = 2'd2;

	entry_t mem [TIMEBASES];
	entry_t rd_s2;

	logic [1:0]  ph_q;
	logic [AW:0] clr_q;
	logic [2:0]  kind_s1;
	logic [AW-1:0] idx_s1;
	logic        ok_s1;
	logic signed [63:0] off_s1;
	logic [63:0] gm_s1, ts_s1;
	logic [31:0] ivl_s1;
	logic        syn_s1, cap_s1;
	logic [3:0]  em_s1, cm_s1;
	logic [30:0] thr_s1;
	logic        ovalid_q;
	logic        valid_idx;
	logic        accept;

	assign valid_idx = 32'(timebase) < TIMEBASES;
	// A read needs a free output register when it completes.
	assign in_ready = (ph_q == PH_IDLE) && !(kind == KIND_READ && ovalid_q && !out_ready);
	assign accept = in_valid && in_ready;

	// Request capture and phase control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_CLEAR;
			clr_q <= '0;
		end else begin
			case (ph_q)
				PH_CLEAR: begin
					if (clr_q == (AW+1)'(TIMEBASES - 1)) ph_q <= PH_IDLE;
					clr_q <= clr_q + 1'b1;
				end
				PH_IDLE: if (accept) ph_q <= PH_MOD;
				PH_MOD: ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1 <= AW'(timebase);
			ok_s1 <= valid_idx;
			off_s1 <= clock_offset;
			gm_s1 <= gm_identity;
			ivl_s1 <= sync_interval;
			syn_s1 <= synced_with_gm;
			cap_s1 <= as_capable;
			ts_s1 <= timestamp_ns;
			em_s1 <= event_mask;
			cm_s1 <= composite_mask;
			thr_s1 <= offset_threshold;
		end
	end

	// Modify the entry read from memory.
	entry_t nx;
	logic   wr_en;
	logic   c;
	always_comb begin
		nx = rd_s2;
		wr_en = 1'b0;
		c = 1'b1;
		if (ph_q == PH_MOD && ok_s1) begin
			case (kind_s1)
				KIND_READ: begin
					wr_en = nx.flags[F_PRESENT];
					nx.c_prange = '0; nx.c_synced = '0; nx.c_gmchg = '0;
					nx.c_cap = '0; nx.c_comp = '0; nx.c_srange = '0;
					nx.flags[F_GMCHG] = 1'b0;
					nx.flags[F_CHANGED] = 1'b0;
				end
				KIND_PTP_SUB: begin
					wr_en = 1'b1;
					nx.flags[F_PRESENT] = 1'b1;
					nx.ptp_mask = em_s1; nx.comp_mask = cm_s1; nx.ptp_thr = thr_s1;
				end
				KIND_SYS_SUB: begin
					wr_en = 1'b1;
					nx.flags[F_PRESENT] = 1'b1;
					nx.sys_mask = em_s1; nx.sys_thr = thr_s1;
				end
				KIND_SYS_UPD: begin
					wr_en = 1'b1;
					nx.flags[F_PRESENT] = 1'b1;
					if (nx.sys_mask[0] && off_s1 != nx.sys_off) begin
						nx.sys_off = off_s1;
						if (in_range(off_s1, nx.sys_thr) != nx.flags[F_SRANGE]) begin
							nx.flags[F_SRANGE] = ~nx.flags[F_SRANGE];
							nx.c_srange = nx.c_srange + 1'b1;
							nx.flags[F_CHANGED] = 1'b1;
						end
					end
					nx.flags[F_SAVAIL] = 1'b1;
				end
				KIND_PTP_UPD: begin
					wr_en = 1'b1;
					nx.flags[F_PRESENT] = 1'b1;
					if (nx.ptp_mask[0] && off_s1 != nx.ptp_off) begin
						nx.ptp_off = off_s1;
						if (in_range(off_s1, nx.ptp_thr) != nx.flags[F_PRANGE]) begin
							nx.flags[F_PRANGE] = ~nx.flags[F_PRANGE];
							nx.c_prange = nx.c_prange + 1'b1;
							nx.flags[F_CHANGED] = 1'b1;
						end
					end
					if (nx.ptp_mask[1] && syn_s1 != nx.flags[F_SYNCED]) begin
						nx.flags[F_SYNCED] = syn_s1;
						nx.c_synced = nx.c_synced + 1'b1;
						nx.flags[F_CHANGED] = 1'b1;
					end
					if (nx.ptp_mask[2] && gm_s1 != nx.gm_id) begin
						nx.gm_id = gm_s1;
						nx.flags[F_GMCHG] = 1'b1;
						nx.flags[F_CHANGED] = 1'b1;
						nx.c_gmchg = nx.c_gmchg + 1'b1;
					end
					if (nx.ptp_mask[3] && cap_s1 != nx.flags[F_CAPABLE]) begin
						nx.flags[F_CAPABLE] = cap_s1;
						nx.c_cap = nx.c_cap + 1'b1;
						nx.flags[F_CHANGED] = 1'b1;
					end
					if (nx.comp_mask != 4'd0) begin
						if (nx.comp_mask[0]) c = c & nx.flags[F_PRANGE];
						if (nx.comp_mask[1]) c = c & nx.flags[F_SYNCED];
						if (nx.comp_mask[3]) c = c & nx.flags[F_CAPABLE];
						if (c != nx.flags[F_COMP]) begin
							nx.flags[F_COMP] = c;
							nx.c_comp = nx.c_comp + 1'b1;
							nx.flags[F_CHANGED] = 1'b1;
						end
					end
					nx.ptp_time = ts_s1;
					nx.ivl = ivl_s1;
					nx.flags[F_PAVAIL] = 1'b1;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	// Entry memory: one read port, one write port, registered read.
	always_ff @(posedge clk) begin
		if (ph_q == PH_CLEAR)
			mem[clr_q[AW-1:0]] <= '0;
		else if (wr_en)
			mem[idx_s1] <= nx;
		if (accept)
			rd_s2 <= mem[AW'(timebase)];
	end

	// Output register for read results.
	logic res_go;
	assign res_go = (ph_q == PH_MOD) && (kind_s1 == KIND_READ);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (res_go)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_go) begin
			if (ok_s1 && rd_s2.flags[F_PRESENT]) begin
				status_flags <= rd_s2.flags;
				ptp_range_count <= rd_s2.c_prange;
				synced_count <= rd_s2.c_synced;
				gm_change_count <= rd_s2.c_gmchg;
				capable_count <= rd_s2.c_cap;
				composite_count <= rd_s2.c_comp;
				sys_range_count <= rd_s2.c_srange;
				ptp_offset <= rd_s2.ptp_off;
				ptp_gm_identity <= rd_s2.gm_id;
				ptp_interval <= rd_s2.ivl;
				sys_offset <= rd_s2.sys_off;
				ptp_time <= rd_s2.ptp_time;
			end else begin
				status_flags <= '0;
				ptp_range_count <= '0;
				synced_count <= '0;
				gm_change_count <= '0;
				capable_count <= '0;
				composite_count <= '0;
				sys_range_count <= '0;
				ptp_offset <= '0;
				ptp_gm_identity <= '0;
				ptp_interval <= '0;
				sys_offset <= '0;
				ptp_time <= '0;
			end
		end
	end
	assign out_valid = ovalid_q;

	// No request is taken during the clearing sweep or the write-back cycle.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_IDLE) |-> !accept) else $error("request taken while busy");
	// Every accepted request is followed by its write-back cycle.
	a_mod_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (ph_q == PH_MOD)) else $error("write-back cycle missing");
	// A read completes only into a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_go |-> (!ovalid_q || out_ready)) else $error("result overwritten");
endmodule
`default_nettype wire

[test/cset_scoreboard.sv]
// Watches both channels of the tracker, predicts each read result and compares it.
module cset_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [3:0]  timebase,
	input  wire logic [63:0] clock_offset,
	input  wire logic [63:0] gm_identity,
	input  wire logic [31:0] sync_interval,
	input  wire logic        synced_with_gm,
	input  wire logic        as_capable,
	input  wire logic [63:0] timestamp_ns,
	input  wire logic [3:0]  event_mask,
	input  wire logic [3:0]  composite_mask,
	input  wire logic [30:0] offset_threshold,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [9:0]  status_flags,
	input  wire logic [31:0] ptp_range_count,
	input  wire logic [31:0] synced_count,
	input  wire logic [31:0] gm_change_count,
	input  wire logic [31:0] capable_count,
	input  wire logic [31:0] composite_count,
	input  wire logic [31:0] sys_range_count,
	input  wire logic [63:0] ptp_offset,
	input  wire logic [63:0] ptp_gm_identity,
	input  wire logic [31:0] ptp_interval,
	input  wire logic [63:0] sys_offset,
	input  wire logic [63:0] ptp_time,
	output int               fail_count,
	output int               pending_reads,
	output int               reads_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import cset_pkg::*;

	typedef struct packed {
		logic [9:0]  flags;
		logic [31:0] c_prange;
		logic [31:0] c_synced;
		logic [31:0] c_gmchg;
		logic [31:0] c_cap;
		logic [31:0] c_comp;
		logic [31:0] c_srange;
		logic [63:0] ptp_off;
		logic [63:0] gm_id;
		logic [31:0] ivl;
		logic [63:0] sys_off;
		logic [63:0] ptp_time;
	} status_rec_t;

	entry_t      table_model [16];
	status_rec_t read_queue[$];

	// Offset within plus or minus the threshold.
	function automatic logic offset_ok(input logic signed [63:0] off, input logic [30:0] thr);
		logic signed [63:0] lim;
		lim = {33'd0, thr};
		return (off >= -lim) && (off <= lim);
	endfunction

	// Set or clear one flag; a change bumps its counter and marks the entry changed.
	function automatic void track_flag(input int idx, input int bitpos, input int cnt,
			input logic val);
		if (table_model[idx].flags[bitpos] == val)
			return;
		table_model[idx].flags[bitpos] = val;
		table_model[idx].flags[F_CHANGED] = 1'b1;
		case (cnt)
		0: table_model[idx].c_prange++;
		1: table_model[idx].c_synced++;
		3: table_model[idx].c_cap++;
		4: table_model[idx].c_comp++;
		default: table_model[idx].c_srange++;
		endcase
	endfunction

	// Apply one accepted request to the model table.
	task automatic apply_request();
		int idx;
		status_rec_t rec;
		logic comp;
		idx = int'(timebase);
		rec = '0;
		if (kind == KIND_READ) begin
			if (table_model[idx].flags[F_PRESENT]) begin
				rec.flags    = table_model[idx].flags;
				rec.c_prange = table_model[idx].c_prange;
				rec.c_synced = table_model[idx].c_synced;
				rec.c_gmchg  = table_model[idx].c_gmchg;
				rec.c_cap    = table_model[idx].c_cap;
				rec.c_comp   = table_model[idx].c_comp;
				rec.c_srange = table_model[idx].c_srange;
				rec.ptp_off  = table_model[idx].ptp_off;
				rec.gm_id    = table_model[idx].gm_id;
				rec.ivl      = table_model[idx].ivl;
				rec.sys_off  = table_model[idx].sys_off;
				rec.ptp_time = table_model[idx].ptp_time;
				{table_model[idx].c_prange, table_model[idx].c_synced,
					table_model[idx].c_gmchg, table_model[idx].c_cap,
					table_model[idx].c_comp, table_model[idx].c_srange} = '0;
				table_model[idx].flags[F_GMCHG] = 1'b0;
				table_model[idx].flags[F_CHANGED] = 1'b0;
			end
			read_queue.push_back(rec);
			return;
		end
		if (kind > KIND_READ)
			return;
		table_model[idx].flags[F_PRESENT] = 1'b1;
		case (kind)
		KIND_PTP_SUB: begin
			table_model[idx].ptp_mask  = event_mask;
			table_model[idx].comp_mask = composite_mask;
			table_model[idx].ptp_thr   = offset_threshold;
		end
		KIND_SYS_SUB: begin
			table_model[idx].sys_mask = event_mask;
			table_model[idx].sys_thr  = offset_threshold;
		end
		KIND_PTP_UPD: begin
			if (table_model[idx].ptp_mask[0] && clock_offset != table_model[idx].ptp_off) begin
				table_model[idx].ptp_off = clock_offset;
				track_flag(idx, F_PRANGE, 0, offset_ok(clock_offset, table_model[idx].ptp_thr));
			end
			if (table_model[idx].ptp_mask[1])
				track_flag(idx, F_SYNCED, 1, synced_with_gm);
			if (table_model[idx].ptp_mask[2] && gm_identity != table_model[idx].gm_id) begin
				table_model[idx].gm_id = gm_identity;
				table_model[idx].flags[F_GMCHG] = 1'b1;
				table_model[idx].flags[F_CHANGED] = 1'b1;
				table_model[idx].c_gmchg++;
			end
			if (table_model[idx].ptp_mask[3])
				track_flag(idx, F_CAPABLE, 3, as_capable);
			if (table_model[idx].comp_mask != 4'd0) begin
				comp = 1'b1;
				if (table_model[idx].comp_mask[0])
					comp &= table_model[idx].flags[F_PRANGE];
				if (table_model[idx].comp_mask[1])
					comp &= table_model[idx].flags[F_SYNCED];
				if (table_model[idx].comp_mask[3])
					comp &= table_model[idx].flags[F_CAPABLE];
				track_flag(idx, F_COMP, 4, comp);
			end
			table_model[idx].ptp_time = timestamp_ns;
			table_model[idx].ivl = sync_interval;
			table_model[idx].flags[F_PAVAIL] = 1'b1;
		end
		default: begin
			if (table_model[idx].sys_mask[0] && clock_offset != table_model[idx].sys_off) begin
				table_model[idx].sys_off = clock_offset;
				track_flag(idx, F_SRANGE, 5, offset_ok(clock_offset, table_model[idx].sys_thr));
			end
			table_model[idx].flags[F_SAVAIL] = 1'b1;
		end
		endcase
	endtask

	// Compare one result with the oldest expectation.
	task automatic check_result();
		status_rec_t got, want;
		got = {status_flags, ptp_range_count, synced_count, gm_change_count, capable_count,
			composite_count, sys_range_count, ptp_offset, ptp_gm_identity, ptp_interval,
			sys_offset, ptp_time};
		reads_seen++;
		if (read_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected result %h", $realtime, got);
			return;
		end
		want = read_queue.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected %h", want);
				$display("  actual   %h", got);
			end
		end
	endtask

	initial begin
		fail_count = 0;
		reads_seen = 0;
		pending_reads = 0;
		foreach (table_model[i])
			table_model[i] = '0;
	end

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_request();
			if (out_valid && out_ready)
				check_result();
		end
		pending_reads = read_queue.size();
	end

	// Report expectations still waiting at the end.
	final begin
		if (read_queue.size() != 0)
			$display("%0d expected results never arrived", read_queue.size());
	end
endmodule

[test/tb_clock_sync_event_tracker.sv]
// Testbench top: drives requests into the tracker and gives the verdict.
module tb_clock_sync_event_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import cset_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [3:0]  timebase = '0;
	logic signed [63:0] clock_offset = '0;
	logic [63:0] gm_identity = '0;
	logic signed [31:0] sync_interval = '0;
	logic        synced_with_gm = 1'b0;
	logic        as_capable = 1'b0;
	logic [63:0] timestamp_ns = '0;
	logic [3:0]  event_mask = '0;
	logic [3:0]  composite_mask = '0;
	logic [30:0] offset_threshold = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [9:0]  status_flags;
	logic [31:0] ptp_range_count, synced_count, gm_change_count;
	logic [31:0] capable_count, composite_count, sys_range_count;
	logic signed [63:0] ptp_offset, sys_offset;
	logic [63:0] ptp_gm_identity, ptp_time;
	logic signed [31:0] ptp_interval;
	int          fail_count, pending_reads, reads_seen;
	int          requests_sent = 0;

	always #5 clk = ~clk;

	clock_sync_event_tracker i_dut (.*);
	cset_scoreboard i_scoreboard (.*);

	// Offer one request and hold it until taken.
	task automatic send(input logic [2:0] k, input logic [3:0] tb, input logic [63:0] off,
			input logic [63:0] gm, input logic [31:0] ivl, input logic syn, input logic cap,
			input logic [63:0] ts, input logic [3:0] em, input logic [3:0] cm,
			input logic [30:0] thr);
		kind = k; timebase = tb; clock_offset = off; gm_identity = gm;
		sync_interval = ivl; synced_with_gm = syn; as_capable = cap; timestamp_ns = ts;
		event_mask = em; composite_mask = cm; offset_threshold = thr;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop valid for a random gap between bursts.
	task automatic idle_gap();
		int n;
		n = $urandom_range(1, 12);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [63:0] rand_off(input bit near);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (near)
			v = 64'($signed($urandom_range(0, 400)) - 200);
		return v;
	endfunction

	// Random request, mostly updates, over all sixteen entries, so that flags move.
	task automatic random_request();
		int sel;
		logic [2:0] k;
		sel = $urandom_range(0, 99);
		k = sel < 40 ? KIND_PTP_UPD : sel < 55 ? KIND_SYS_UPD : sel < 65 ? KIND_PTP_SUB :
			sel < 72 ? KIND_SYS_SUB : sel < 97 ? KIND_READ : 3'($urandom_range(5, 7));
		send(k, 4'($urandom_range(0, 15)), rand_off($urandom_range(0, 3) != 0),
			$urandom_range(0, 2) == 0 ? {$urandom, $urandom} : 64'($urandom_range(0, 2)),
			$urandom, 1'($urandom), 1'($urandom), {$urandom, $urandom},
			4'($urandom), 4'($urandom),
			$urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 150)));
	endtask

	// Receiver: alternating stretches of steady acceptance and random stalls.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				@(negedge clk);
				out_ready <= mode == 0 ? 1'b1 : mode == 1 ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 4) == 0);
			end
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: absent read, extremes, every kind, wrap of threshold limits.
		send(KIND_READ, 4'd15, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_PTP_SUB, 4'd0, '0, '0, '0, 1'b0, 1'b0, '0, 4'hf, 4'hb, 31'h7fffffff);
		send(KIND_PTP_UPD, 4'd0, 64'h8000000000000000, '1, 32'h80000000, 1'b1, 1'b1, '1,
			'0, '0, '0);
		send(KIND_PTP_UPD, 4'd0, 64'h7fffffffffffffff, '0, 32'h7fffffff, 1'b0, 1'b0, '0,
			'0, '0, '0);
		send(KIND_PTP_UPD, 4'd0, 64'h7fffffff, 64'd5, '1, 1'b1, 1'b1, 64'd9, '0, '0, '0);
		send(KIND_PTP_UPD, 4'd0, 64'h7fffffff, 64'd5, '1, 1'b1, 1'b1, 64'd9, '0, '0, '0);
		send(KIND_READ, 4'd0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_PTP_SUB, 4'd1, '0, '0, '0, 1'b0, 1'b0, '0, 4'h4, 4'h4, 31'd0);
		send(KIND_PTP_UPD, 4'd1, 64'd1, 64'd77, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_READ, 4'd1, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_SYS_SUB, 4'd2, '0, '0, '0, 1'b0, 1'b0, '0, 4'h1, '0, 31'd10);
		send(KIND_SYS_UPD, 4'd2, -64'sd10, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_SYS_UPD, 4'd2, -64'sd11, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(3'd7, 4'd3, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_READ, 4'd3, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_READ, 4'd2, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_SYS_UPD, 4'd4, '1, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		send(KIND_READ, 4'd4, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0);

		// Hold off until every read has come back.
		in_valid <= 1'b0;
		while (pending_reads != 0) @(negedge clk);

		// Random bursts with gaps, some bursts back to back.
		while (requests_sent < 1900) begin
			repeat ($urandom_range(1, 20)) random_request();
			if ($urandom_range(0, 2) != 0)
				idle_gap();
		end
		in_valid <= 1'b0;
		while (pending_reads != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Sent %0d requests over sixteen entries and checked %0d read results.",
			requests_sent, reads_seen);
		if (fail_count == 0 && pending_reads == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
